FILE: src/clle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clle_pkg: shared types and microcode for the cursor linked list engine
// payload widths, request and status codes, control word, microcode rom
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int VAL_W  = 32;
    localparam int REQ_W  = 3;
    localparam int CNT_W  = 9;
    localparam int UPC_W  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FORWARD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BACKWARD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TO_HEAD  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TO_TAIL  = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_END   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } stat_t;

    // datapath actions, one per control word
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_ALLOC,
        ACT_MID_A,
        ACT_MID_B,
        ACT_APPEND,
        ACT_PUSH,
        ACT_UNLINK,
        ACT_CLEAR,
        ACT_DROP_HEAD,
        ACT_DROP_TAIL,
        ACT_CUR_NEXT,
        ACT_CUR_PREV,
        ACT_CUR_HEAD,
        ACT_CUR_TAIL,
        ACT_ST_END,
        ACT_ST_FULL,
        ACT_ST_EMPTY,
        ACT_OUT
    } act_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_FULL,
        C_EMPTY,
        C_CUR_HEAD,
        C_CUR_TAIL,
        C_HEAD_OR_EMPTY,
        C_TAIL_OR_EMPTY
    } cond_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic cur_head;
        logic cur_tail;
        logic out_free;
    } dp_flags_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cursor_value;
        logic                    list_empty;
        logic                    at_head;
        logic                    at_tail;
        logic [CNT_W-1:0]        element_count;
        stat_t                   op_status;
    } rsp_t;

    // microcode addresses
    localparam upc_t UA_INS_ALLOC  = 5'd0;
    localparam upc_t UA_INS_SPLIT  = 5'd1;
    localparam upc_t UA_INS_MID_A  = 5'd2;
    localparam upc_t UA_INS_MID_B  = 5'd3;
    localparam upc_t UA_INS_APPEND = 5'd4;
    localparam upc_t UA_ERS_PUSH   = 5'd5;
    localparam upc_t UA_ERS_LAST   = 5'd6;
    localparam upc_t UA_ERS_HEAD   = 5'd7;
    localparam upc_t UA_ERS_TAIL   = 5'd8;
    localparam upc_t UA_ERS_MID    = 5'd9;
    localparam upc_t UA_ERS_CLEAR  = 5'd10;
    localparam upc_t UA_ERS_DHEAD  = 5'd11;
    localparam upc_t UA_ERS_DTAIL  = 5'd12;
    localparam upc_t UA_FWD_CHECK  = 5'd13;
    localparam upc_t UA_FWD_MOVE   = 5'd14;
    localparam upc_t UA_BWD_CHECK  = 5'd15;
    localparam upc_t UA_BWD_MOVE   = 5'd16;
    localparam upc_t UA_GO_HEAD    = 5'd17;
    localparam upc_t UA_GO_TAIL    = 5'd18;
    localparam upc_t UA_REFUSE     = 5'd19;
    localparam upc_t UA_FULL       = 5'd20;
    localparam upc_t UA_ERS_EMPTY  = 5'd21;
    localparam upc_t UA_OUT        = 5'd22;

    // microcode rom
    function automatic uword_t ucode(input upc_t a);
        uword_t w;
        w = '{act: ACT_OUT, cond: C_NEVER, target: UA_OUT};
        unique case (a)
            UA_INS_ALLOC:  w = '{act: ACT_ALLOC,     cond: C_FULL,     target: UA_FULL};
            UA_INS_SPLIT:  w = '{act: ACT_NONE,      cond: C_CUR_TAIL, target: UA_INS_APPEND};
            UA_INS_MID_A:  w = '{act: ACT_MID_A,     cond: C_NEVER,    target: UA_OUT};
            UA_INS_MID_B:  w = '{act: ACT_MID_B,     cond: C_ALWAYS,   target: UA_OUT};
            UA_INS_APPEND: w = '{act: ACT_APPEND,    cond: C_ALWAYS,   target: UA_OUT};
            UA_ERS_PUSH:   w = '{act: ACT_PUSH,      cond: C_EMPTY,    target: UA_ERS_EMPTY};
            UA_ERS_LAST:   w = '{act: ACT_NONE,      cond: C_EMPTY,    target: UA_ERS_CLEAR};
            UA_ERS_HEAD:   w = '{act: ACT_NONE,      cond: C_CUR_HEAD, target: UA_ERS_DHEAD};
            UA_ERS_TAIL:   w = '{act: ACT_NONE,      cond: C_CUR_TAIL, target: UA_ERS_DTAIL};
            UA_ERS_MID:    w = '{act: ACT_UNLINK,    cond: C_ALWAYS,   target: UA_OUT};
            UA_ERS_CLEAR:  w = '{act: ACT_CLEAR,     cond: C_ALWAYS,   target: UA_OUT};
            UA_ERS_DHEAD:  w = '{act: ACT_DROP_HEAD, cond: C_ALWAYS,   target: UA_OUT};
            UA_ERS_DTAIL:  w = '{act: ACT_DROP_TAIL, cond: C_ALWAYS,   target: UA_OUT};
            UA_FWD_CHECK:  w = '{act: ACT_NONE,      cond: C_TAIL_OR_EMPTY, target: UA_REFUSE};
            UA_FWD_MOVE:   w = '{act: ACT_CUR_NEXT,  cond: C_ALWAYS,   target: UA_OUT};
            UA_BWD_CHECK:  w = '{act: ACT_NONE,      cond: C_HEAD_OR_EMPTY, target: UA_REFUSE};
            UA_BWD_MOVE:   w = '{act: ACT_CUR_PREV,  cond: C_ALWAYS,   target: UA_OUT};
            UA_GO_HEAD:    w = '{act: ACT_CUR_HEAD,  cond: C_ALWAYS,   target: UA_OUT};
            UA_GO_TAIL:    w = '{act: ACT_CUR_TAIL,  cond: C_ALWAYS,   target: UA_OUT};
            UA_REFUSE:     w = '{act: ACT_ST_END,    cond: C_ALWAYS,   target: UA_OUT};
            UA_FULL:       w = '{act: ACT_ST_FULL,   cond: C_ALWAYS,   target: UA_OUT};
            UA_ERS_EMPTY:  w = '{act: ACT_ST_EMPTY,  cond: C_ALWAYS,   target: UA_OUT};
            default:       w = '{act: ACT_OUT,       cond: C_NEVER,    target: UA_OUT};
        endcase
        return w;
    endfunction

    // dispatch table: first microcode step of each request
    function automatic upc_t entry_of(input logic [REQ_W-1:0] req);
        upc_t a;
        a = UA_OUT;
        unique case (req)
            REQ_INSERT:   a = UA_INS_ALLOC;
            REQ_ERASE:    a = UA_ERS_PUSH;
            REQ_FORWARD:  a = UA_FWD_CHECK;
            REQ_BACKWARD: a = UA_BWD_CHECK;
            REQ_TO_HEAD:  a = UA_GO_HEAD;
            REQ_TO_TAIL:  a = UA_GO_TAIL;
            default:      a = UA_OUT;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: src/clle_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clle_req_if: request channel
// valid/ready handshake carrying one list request item
// ----------------------------------------------------------------------------
interface clle_req_if;
    import clle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output req_type, output new_value, input ready);
    modport sink   (input valid, input req_type, input new_value, output ready);
endinterface
`default_nettype wire

FILE: src/clle_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clle_rsp_if: result channel
// valid/ready handshake carrying one result item per request
// ----------------------------------------------------------------------------
interface clle_rsp_if;
    import clle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] cursor_value;
    logic                    list_empty;
    logic                    at_head;
    logic                    at_tail;
    logic [CNT_W-1:0]        element_count;
    logic [1:0]              op_status;

    modport source (output valid, output cursor_value, output list_empty, output at_head,
                    output at_tail, output element_count, output op_status, input ready);
    modport sink   (input valid, input cursor_value, input list_empty, input at_head,
                    input at_tail, input element_count, input op_status, output ready);
endinterface
`default_nettype wire

FILE: src/clle_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clle_useq: microcode sequencer
// step counter over the control rom, conditional jumps, request dispatch
// ----------------------------------------------------------------------------
module clle_useq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clle_pkg::REQ_W-1:0]    req_type,
    input  clle_pkg::dp_flags_t           flags,
    output clle_pkg::act_t                act,
    output logic                          can_start
);
    import clle_pkg::*;

    logic   busy_reg;
    upc_t   upc_reg;
    uword_t word;
    logic   taken;

    always_comb
    begin
        word = ucode(upc_reg);
        unique case (word.cond)
            C_NEVER:         taken = 1'b0;
            C_ALWAYS:        taken = 1'b1;
            C_FULL:          taken = flags.full;
            C_EMPTY:         taken = flags.empty;
            C_CUR_HEAD:      taken = flags.cur_head;
            C_CUR_TAIL:      taken = flags.cur_tail;
            C_HEAD_OR_EMPTY: taken = flags.cur_head | flags.empty;
            C_TAIL_OR_EMPTY: taken = flags.cur_tail | flags.empty;
            default:         taken = 1'b0;
        endcase
        act       = busy_reg ? word.act : ACT_NONE;
        // next request may enter on the edge that hands off the result
        can_start = !busy_reg || (word.act == ACT_OUT && flags.out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= UA_OUT;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            upc_reg  <= entry_of(req_type);
        end
        else if (busy_reg)
        begin
            if (word.act == ACT_OUT)
            begin
                if (flags.out_free)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (taken)
            begin
                upc_reg <= word.target;
            end
            else
            begin
                upc_reg <= upc_reg + 5'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/clle_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clle_dpath: list datapath
// node pool memories, free slot stack, head/tail/cursor registers, result reg
// ----------------------------------------------------------------------------
module clle_dpath #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [clle_pkg::VAL_W-1:0]   new_value,
    input  clle_pkg::act_t                      act,
    output clle_pkg::dp_flags_t                 flags,
    output clle_pkg::rsp_t                      rsp_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready
);
    import clle_pkg::*;

    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // pool memories
    logic signed [VALUE_BITS-1:0] value_mem [CAPACITY];
    slot_t                        next_mem  [CAPACITY];
    slot_t                        prev_mem  [CAPACITY];
    slot_t                        free_mem  [CAPACITY];

    logic signed [VALUE_BITS-1:0] value_q;
    slot_t                        next_q;
    slot_t                        prev_q;
    slot_t                        free_q;

    // control registers
    slot_t cur_reg,   cur_next;
    slot_t head_reg,  head_next;
    slot_t tail_reg,  tail_next;
    cnt_t  cnt_reg,   cnt_next;
    cnt_t  fresh_reg, fresh_next;
    cnt_t  fsp_reg,   fsp_next;
    logic  rsp_valid_reg, rsp_valid_next;

    // payload registers
    slot_t                   s_reg,  s_next;
    slot_t                   nb_reg, nb_next;
    slot_t                   pb_reg, pb_next;
    logic signed [VAL_W-1:0] v_reg,  v_next;
    stat_t                   stat_reg, stat_next;
    rsp_t                    rsp_reg, rsp_next;

    // write ports
    logic  val_we, nx_we, pv_we, fr_we;
    slot_t val_wa, nx_wa, pv_wa, fr_wa;
    slot_t nx_wd, pv_wd, fr_wd;

    logic  empty, full, from_stack, do_out;
    cnt_t  fsp_m1;
    slot_t slot_new;

    always_comb
    begin
        empty      = (cnt_reg == '0);
        full       = (cnt_reg == CNT_BITS'(CAPACITY));
        from_stack = (fsp_reg != '0);
        fsp_m1     = fsp_reg - 1'b1;
        // recycled slot first, otherwise one never used yet
        slot_new   = from_stack ? free_q : fresh_reg[SLOT_BITS-1:0];
        do_out     = (act == ACT_OUT) && (!rsp_valid_reg || rsp_ready);

        flags.full     = full;
        flags.empty    = empty;
        flags.cur_head = (cur_reg == head_reg);
        flags.cur_tail = (cur_reg == tail_reg);
        flags.out_free = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        cur_next   = cur_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        fsp_next   = fsp_reg;
        s_next     = s_reg;
        nb_next    = nb_reg;
        pb_next    = pb_reg;
        v_next     = v_reg;
        stat_next  = stat_reg;
        rsp_next   = rsp_reg;
        val_we = 1'b0;  val_wa = s_reg;
        nx_we  = 1'b0;  nx_wa  = cur_reg;  nx_wd = s_reg;
        pv_we  = 1'b0;  pv_wa  = s_reg;    pv_wd = cur_reg;
        fr_we  = 1'b0;  fr_wa  = fsp_reg[SLOT_BITS-1:0];  fr_wd = cur_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (act)
            ACT_NONE:
            begin
            end
            ACT_ALLOC:
            begin
                if (!full)
                begin
                    s_next = slot_new;
                    val_we = 1'b1;
                    val_wa = slot_new;
                    if (from_stack)
                    begin
                        fsp_next = fsp_m1;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                end
            end
            ACT_MID_A:
            begin
                nb_next = next_q;
                nx_we = 1'b1;  nx_wa = cur_reg;  nx_wd = s_reg;
                pv_we = 1'b1;  pv_wa = s_reg;    pv_wd = cur_reg;
            end
            ACT_MID_B:
            begin
                nx_we = 1'b1;  nx_wa = s_reg;   nx_wd = nb_reg;
                pv_we = 1'b1;  pv_wa = nb_reg;  pv_wd = s_reg;
                cur_next = s_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            ACT_APPEND:
            begin
                if (empty)
                begin
                    head_next = s_reg;
                end
                else
                begin
                    nx_we = 1'b1;  nx_wa = cur_reg;  nx_wd = s_reg;
                    pv_we = 1'b1;  pv_wa = s_reg;    pv_wd = cur_reg;
                end
                tail_next = s_reg;
                cur_next  = s_reg;
                cnt_next  = cnt_reg + 1'b1;
            end
            ACT_PUSH:
            begin
                nb_next = next_q;
                pb_next = prev_q;
                if (!empty)
                begin
                    fr_we    = 1'b1;
                    fsp_next = fsp_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ACT_UNLINK:
            begin
                nx_we = 1'b1;  nx_wa = pb_reg;  nx_wd = nb_reg;
                pv_we = 1'b1;  pv_wa = nb_reg;  pv_wd = pb_reg;
                cur_next = nb_reg;
            end
            ACT_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                cur_next  = '0;
            end
            ACT_DROP_HEAD:
            begin
                head_next = nb_reg;
                cur_next  = nb_reg;
            end
            ACT_DROP_TAIL:
            begin
                tail_next = pb_reg;
                cur_next  = pb_reg;
            end
            ACT_CUR_NEXT:  cur_next  = next_q;
            ACT_CUR_PREV:  cur_next  = prev_q;
            ACT_CUR_HEAD:  cur_next  = head_reg;
            ACT_CUR_TAIL:  cur_next  = tail_reg;
            ACT_ST_END:    stat_next = STAT_END;
            ACT_ST_FULL:   stat_next = STAT_FULL;
            ACT_ST_EMPTY:  stat_next = STAT_EMPTY;
            ACT_OUT:
            begin
                if (do_out)
                begin
                    rsp_next.cursor_value  = empty ? '0 : VAL_W'(value_q);
                    rsp_next.list_empty    = empty;
                    rsp_next.at_head       = empty || (cur_reg == head_reg);
                    rsp_next.at_tail       = empty || (cur_reg == tail_reg);
                    rsp_next.element_count = CNT_W'(cnt_reg);
                    rsp_next.op_status     = stat_reg;
                    rsp_valid_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (start)
        begin
            v_next    = new_value;
            stat_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            fresh_reg     <= '0;
            fsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            fsp_reg       <= fsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        nb_reg   <= nb_next;
        pb_reg   <= pb_next;
        v_reg    <= v_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    // value read follows the cursor as it is being updated
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_wa] <= VALUE_BITS'(v_reg);
        end
        value_q <= value_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        next_q <= next_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        prev_q <= prev_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            free_mem[fr_wa] <= fr_wd;
        end
        free_q <= free_mem[fsp_m1[SLOT_BITS-1:0]];
    end

    assign rsp_data  = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

FILE: src/cursor_linked_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit: doubly linked list with cursor
// microcoded sequencer over a node pool with next/prev links and a free stack
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  req     | in  | req_type, new_value                              | valid/ready
//  rsp     | out | cursor_value, list_empty, at_head, at_tail,      | valid/ready
//          |     | element_count, op_status                         |
//
//  steps: each request runs its own microcode path, chosen by its type and the list state
//  the pool memories have one write port each, so link updates are serialized
//  reset: list empty, cursor/head/tail at slot zero, no pool clearing pass
//  stalls: a result waits in the output register; the next item enters on the
//    edge that hands the result over, and the sequencer holds while it waits
//
module cursor_linked_list_engine_unit #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    clle_req_if.sink    req,
    clle_rsp_if.source  rsp
);
    import clle_pkg::*;

    act_t      act;
    dp_flags_t flags;
    rsp_t      rsp_data;
    logic      can_start;
    logic      start;

    // request accepted when sequencer is free or is handing over its result
    assign req.ready = can_start;
    assign start     = req.valid && can_start;

    // control: rom program, step counter and jumps
    clle_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req.req_type),
        .flags     (flags),
        .act       (act),
        .can_start (can_start)
    );

    // datapath: pool memories, list pointers, result register
    clle_dpath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .new_value (req.new_value),
        .act       (act),
        .flags     (flags),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

    // result item fields
    assign rsp.cursor_value  = rsp_data.cursor_value;
    assign rsp.list_empty    = rsp_data.list_empty;
    assign rsp.at_head       = rsp_data.at_head;
    assign rsp.at_tail       = rsp_data.at_tail;
    assign rsp.element_count = rsp_data.element_count;
    assign rsp.op_status     = rsp_data.op_status;

endmodule
`default_nettype wire
